@@ hw/rtl/wlte_pkg.sv @@
// ----------------------------------------------------------------------------
// wlte_pkg
// Shared widths, operation codes and status codes of the word list engine.
// ----------------------------------------------------------------------------
package wlte_pkg;

  localparam int unsigned DEPTH_DEF     = 256;
  localparam int unsigned WORD_BITS_DEF = 64;

  localparam int unsigned MODE_W   = 4;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned NCOUNT_W = 9;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;

  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 88;

  localparam logic [MODE_W-1:0] M_APPEND   = 4'd0;
  localparam logic [MODE_W-1:0] M_WRITE    = 4'd1;
  localparam logic [MODE_W-1:0] M_READ     = 4'd2;
  localparam logic [MODE_W-1:0] M_REMOVE   = 4'd3;
  localparam logic [MODE_W-1:0] M_FREMOVE  = 4'd4;
  localparam logic [MODE_W-1:0] M_FIND     = 4'd5;
  localparam logic [MODE_W-1:0] M_REMVAL   = 4'd6;
  localparam logic [MODE_W-1:0] M_FREMVAL  = 4'd7;
  localparam logic [MODE_W-1:0] M_SETCOUNT = 4'd8;
  localparam logic [MODE_W-1:0] M_CLEAR    = 4'd9;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd3;

endpackage

@@ hw/rtl/word_list_table_engine_unit.sv @@
// ----------------------------------------------------------------------------
// word_list_table_engine_unit
// Count, write and append items pass accept, EXEC and DONE; read and fast
// remove add a read-wait state (RDW or FRW); find walks one entry a cycle,
// ordered remove moves one entry a cycle through the store's separate read and
// write ports. Throughput: one item at a time; the next item is taken once the
// result sits in the output register. Reset: count cleared, then a sweep zeroes
// the store with in_tready low.
// ----------------------------------------------------------------------------
module word_list_table_engine_unit
  import wlte_pkg::*;
#(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // index[7:0], value[71:8], new_count[80:72], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode[3:0]
  input  logic [MODE_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status[1:0], read_value[65:2], found_index[73:66], count[82:74], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > NCOUNT_W) ? CW : NCOUNT_W;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_RDW   = 3'd3;
  localparam logic [2:0] S_FRW   = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;
  localparam logic [2:0] S_FIND  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [INDEX_W-1:0]   idx_r, idx_nxt;
  logic [WORD_BITS-1:0] val_r, val_nxt;
  logic [NCOUNT_W-1:0]  ncnt_r, ncnt_nxt;
  logic [CW-1:0]        ptr_r, ptr_nxt;
  logic [AW-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                 cmp_v_r, cmp_v_nxt;
  logic                 pend_r, pend_nxt;
  logic [AW-1:0]        pend_wa_r, pend_wa_nxt;
  logic [AW-1:0]        tgt_r, tgt_nxt;
  logic [STATUS_W-1:0]  res_st_r, res_st_nxt;
  logic [WORD_BITS-1:0] res_rd_r, res_rd_nxt;
  logic [AW-1:0]        res_pos_r, res_pos_nxt;
  logic                 out_v_r, out_v_nxt;
  logic [OUT_DATA_W-1:0] out_d_r, out_d_nxt;

  logic [WORD_BITS-1:0] mem_r [DEPTH];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 we, re;
  logic [AW-1:0]        wa, ra;
  logic [WORD_BITS-1:0] wd;

  logic [CW-1:0] cnt_dec, ptr_dec;
  logic          idx_lt_cnt, idx_lt_depth, match, out_free;

  assign cnt_dec      = cnt_r - CW'(1);
  assign ptr_dec      = ptr_r - CW'(1);
  assign idx_lt_cnt   = XW'(idx_r) < XW'(cnt_r);
  assign idx_lt_depth = XW'(idx_r) < XW'(DEPTH);
  assign match        = cmp_v_r && (rdata_r == val_r);
  assign out_free     = !out_v_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    clr_nxt     = clr_r;
    mode_nxt    = mode_r;
    idx_nxt     = idx_r;
    val_nxt     = val_r;
    ncnt_nxt    = ncnt_r;
    ptr_nxt     = ptr_r;
    cmp_idx_nxt = cmp_idx_r;
    cmp_v_nxt   = cmp_v_r;
    pend_nxt    = pend_r;
    pend_wa_nxt = pend_wa_r;
    tgt_nxt     = tgt_r;
    res_st_nxt  = res_st_r;
    res_rd_nxt  = res_rd_r;
    res_pos_nxt = res_pos_r;
    out_v_nxt   = out_v_r && !out_tready;
    out_d_nxt   = out_d_r;
    we = 1'b0;
    re = 1'b0;
    wa = '0;
    ra = '0;
    wd = '0;
    case (state_r)
      S_CLR: begin
        we      = 1'b1;
        wa      = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt    = in_tuser;
          idx_nxt     = in_tdata[7:0];
          val_nxt     = WORD_BITS'(in_tdata[71:8]);
          ncnt_nxt    = in_tdata[80:72];
          res_st_nxt  = ST_OK;
          res_rd_nxt  = '0;
          res_pos_nxt = '0;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (mode_r)
          M_APPEND: begin
            if (cnt_r == CW'(DEPTH)) begin
              res_st_nxt = ST_FULL;
            end else begin
              we      = 1'b1;
              wa      = cnt_r[AW-1:0];
              wd      = val_r;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          M_WRITE: begin
            if (idx_lt_cnt) begin
              we = 1'b1;
              wa = AW'(idx_r);
              wd = val_r;
            end else begin
              res_st_nxt = ST_MISS;
            end
          end
          M_READ: begin
            if (idx_lt_depth) begin
              re        = 1'b1;
              ra        = AW'(idx_r);
              state_nxt = S_RDW;
            end else begin
              res_st_nxt = ST_MISS;
            end
          end
          M_REMOVE: begin
            if (idx_lt_cnt) begin
              ptr_nxt   = CW'(idx_r) + CW'(1);
              pend_nxt  = 1'b0;
              state_nxt = S_SHIFT;
            end else begin
              res_st_nxt = ST_MISS;
            end
          end
          M_FREMOVE: begin
            if (idx_lt_cnt) begin
              re        = 1'b1;
              ra        = cnt_dec[AW-1:0];
              tgt_nxt   = AW'(idx_r);
              state_nxt = S_FRW;
            end else begin
              res_st_nxt = ST_MISS;
            end
          end
          M_FIND, M_REMVAL, M_FREMVAL: begin
            ptr_nxt   = '0;
            cmp_v_nxt = 1'b0;
            state_nxt = S_FIND;
          end
          M_SETCOUNT: begin
            if (XW'(ncnt_r) > XW'(DEPTH)) begin
              cnt_nxt = CW'(DEPTH);
            end else begin
              cnt_nxt = CW'(ncnt_r);
            end
          end
          M_CLEAR: begin
            cnt_nxt = '0;
          end
          default: begin
            res_st_nxt = ST_MISS;
          end
        endcase
      end
      S_RDW: begin
        res_rd_nxt = rdata_r;
        state_nxt  = S_DONE;
      end
      S_FRW: begin
        we        = 1'b1;
        wa        = tgt_r;
        wd        = rdata_r;
        cnt_nxt   = cnt_dec;
        state_nxt = S_DONE;
      end
      S_SHIFT: begin
        if (pend_r) begin
          we = 1'b1;
          wa = pend_wa_r;
          wd = rdata_r;
        end
        if (ptr_r < cnt_r) begin
          re          = 1'b1;
          ra          = ptr_r[AW-1:0];
          pend_nxt    = 1'b1;
          pend_wa_nxt = ptr_dec[AW-1:0];
          ptr_nxt     = ptr_r + CW'(1);
        end else begin
          pend_nxt  = 1'b0;
          cnt_nxt   = cnt_dec;
          state_nxt = S_DONE;
        end
      end
      S_FIND: begin
        if (match) begin
          res_pos_nxt = cmp_idx_r;
          cmp_v_nxt   = 1'b0;
          case (mode_r)
            M_REMVAL: begin
              ptr_nxt   = CW'(cmp_idx_r) + CW'(1);
              pend_nxt  = 1'b0;
              state_nxt = S_SHIFT;
            end
            M_FREMVAL: begin
              re        = 1'b1;
              ra        = cnt_dec[AW-1:0];
              tgt_nxt   = cmp_idx_r;
              state_nxt = S_FRW;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end else if (ptr_r < cnt_r) begin
          re          = 1'b1;
          ra          = ptr_r[AW-1:0];
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = ptr_r[AW-1:0];
          ptr_nxt     = ptr_r + CW'(1);
        end else begin
          cmp_v_nxt  = 1'b0;
          res_st_nxt = ST_MISS;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_v_nxt = 1'b1;
          out_d_nxt = '0;
          out_d_nxt[1:0]   = res_st_r;
          out_d_nxt[65:2]  = VALUE_W'(res_rd_r);
          out_d_nxt[73:66] = INDEX_W'(res_pos_r);
          out_d_nxt[82:74] = COUNT_W'(cnt_r);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      clr_r   <= '0;
      out_v_r <= 1'b0;
      pend_r  <= 1'b0;
      cmp_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
      out_v_r <= out_v_nxt;
      pend_r  <= pend_nxt;
      cmp_v_r <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    ncnt_r    <= ncnt_nxt;
    ptr_r     <= ptr_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    pend_wa_r <= pend_wa_nxt;
    tgt_r     <= tgt_nxt;
    res_st_r  <= res_st_nxt;
    res_rd_r  <= res_rd_nxt;
    res_pos_r <= res_pos_nxt;
    out_d_r   <= out_d_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem_r[ra];
    end
  end

endmodule

@@ hw/rtl/wlte_chk.sv @@
// ----------------------------------------------------------------------------
// wlte_chk
// Port-level checks of the word list engine, bound to the top level.
// ----------------------------------------------------------------------------
module wlte_chk
  import wlte_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("item taken during store clearing");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken before first finished");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != ST_BAD)
    else $error("undefined status code");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ST_FULL |-> out_tdata[82:74] == COUNT_W'(DEPTH))
    else $error("list full reported below capacity");

endmodule

bind word_list_table_engine_unit wlte_chk #(.DEPTH(DEPTH)) u_wlte_chk (.*);
